// ===== src/sitrt_pkg.sv =====
package sitrt_pkg;

    // Field and register widths
    localparam int VALUE_W     = 32;
    localparam int MAG_W       = 32;
    localparam int SYM_W       = 8;
    localparam int RADIX_W     = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Alphabet layout: four words of eight symbols
    localparam int ALPHA_WORDS = 4;
    localparam int ALPHA_SYMS  = 32;
    localparam int SYM_IDX_W   = 5;

    localparam int DEFAULT_MAX_RADIX = 32;

    // Digit stack: a 32-bit magnitude has at most 32 digits (radix 2)
    localparam int MAX_DIGITS  = 32;
    localparam int DIGIT_IDX_W = 5;
    localparam int DIGIT_CNT_W = 6;

    // Long division: quotient bits resolved per cycle, division steps per digit
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS     = MAG_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 2;

    // Special symbols
    localparam logic [SYM_W-1:0] MINUS_SYM = 8'h2D;
    localparam logic [SYM_W-1:0] PLUS_SYM  = 8'h2B;
    localparam logic [SYM_W-1:0] NUL_SYM   = 8'h00;

    // Reset values of the configuration registers
    localparam logic [RADIX_W-1:0]    RADIX_RESET   = 6'd10;
    localparam logic [CFG_DATA_W-1:0] ALPHA_RESET_0 = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] ALPHA_RESET_1 = 64'h0000000000003938;
    localparam logic [CFG_DATA_W-1:0] ALPHA_RESET_2 = 64'h0;
    localparam logic [CFG_DATA_W-1:0] ALPHA_RESET_3 = 64'h0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX   = 3'd0,
        CFG_ALPHA_0 = 3'd1,
        CFG_ALPHA_1 = 3'd2,
        CFG_ALPHA_2 = 3'd3,
        CFG_ALPHA_3 = 3'd4
    } t_cfg_idx;

    typedef logic [SYM_IDX_W-1:0] t_sym_idx;

    // Symbol k sits at bits 8k+7:8k, word 0 in the low bits
    typedef logic [ALPHA_SYMS-1:0][SYM_W-1:0] t_alpha;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_item;

endpackage

// ===== src/sitrt_front.sv =====
module sitrt_front
    import sitrt_pkg::*;
#(
    parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_busy,
    input  logic [RADIX_W-1:0] i_radix,
    input  t_alpha             i_alpha,
    output logic               o_push,
    output t_item              o_item,
    input  logic               i_full
);

    localparam int DW = $clog2(MAX_RADIX);

    typedef enum logic [1:0] {
        F_IDLE,
        F_CHECK,
        F_PUSH
    } t_fstate;

    t_fstate         r_state, n_state;
    logic [DW-1:0]   r_idx, n_idx;
    t_item           r_item, n_item;

    logic             radix_ok;
    logic [SYM_W-1:0] sym;
    logic             sym_bad;
    logic             idx_last;

    assign radix_ok = (i_radix >= RADIX_W'(2)) && (i_radix <= RADIX_W'(MAX_RADIX));

    // Check symbol idx against the reserved bytes and every later symbol in use
    always_comb begin
        sym     = i_alpha[t_sym_idx'(r_idx)];
        sym_bad = (sym == NUL_SYM) || (sym == PLUS_SYM) || (sym == MINUS_SYM);
        for (int j = 0; j < MAX_RADIX; j++) begin
            if ((DW'(j) > r_idx) && (RADIX_W'(j) < i_radix) && (i_alpha[j] == sym)) begin
                sym_bad = 1'b1;
            end
        end
    end

    assign idx_last = (RADIX_W'(r_idx) == (i_radix - RADIX_W'(1)));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_item  = r_item;
        case (r_state)
            F_IDLE: begin
                // Take the value; drop it at once if the radix is out of range
                if (i_start) begin
                    n_item.neg = i_value[VALUE_W-1];
                    n_item.mag = i_value[VALUE_W-1] ? (MAG_W'(0) - i_value) : i_value;
                    n_idx      = '0;
                    if (radix_ok) begin
                        n_state = F_CHECK;
                    end
                end
            end
            F_CHECK: begin
                if (sym_bad) begin
                    n_state = F_IDLE;
                end else if (idx_last) begin
                    n_state = F_PUSH;
                end else begin
                    n_idx = r_idx + DW'(1);
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Hold state and the classified item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_item <= n_item;
    end

    assign o_busy = (r_state != F_IDLE) || !i_rst_n;
    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_item = r_item;

endmodule

// ===== src/sitrt_fifo.sv =====
module sitrt_fifo
    import sitrt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/sitrt_back.sv =====
module sitrt_back
    import sitrt_pkg::*;
#(
    parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_item              i_item,
    output logic               o_pop,
    input  logic [RADIX_W-1:0] i_radix,
    input  t_alpha             i_alpha,
    output logic               o_strobe,
    output logic [SYM_W-1:0]   o_symbol,
    output logic               o_last
);

    localparam int DW = $clog2(MAX_RADIX);

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_SIGN,
        B_EMIT
    } t_bstate;

    t_bstate                  r_state, n_state;
    logic [MAG_W-1:0]         r_quot, n_quot;
    logic [DW-1:0]            r_rem, n_rem;
    logic [STEP_W-1:0]        r_step, n_step;
    logic [DIGIT_CNT_W-1:0]   r_nd, n_nd;
    logic                     r_neg, n_neg;
    logic [DW-1:0]            r_digits [MAX_DIGITS];
    logic                     r_strobe, n_strobe;
    logic [SYM_W-1:0]         r_symbol, n_symbol;
    logic                     r_last, n_last;

    logic [DW:0]              rdx;
    logic [DW-1:0]            rem_w;
    logic [DW:0]              sh;
    logic [BITS_PER_STEP-1:0] qbits;
    logic [MAG_W-1:0]         quot_next;
    logic                     digit_wr;
    logic [DIGIT_IDX_W-1:0]   rd_idx;

    // Radix fits DW+1 bits once the front has accepted the item
    assign rdx = (DW+1)'(i_radix);

    // Resolve the next eight quotient bits by restoring division
    always_comb begin
        rem_w = r_rem;
        qbits = '0;
        sh    = '0;
        for (int b = BITS_PER_STEP - 1; b >= 0; b--) begin
            sh = {rem_w, r_quot[MAG_W - BITS_PER_STEP + b]};
            if (sh >= rdx) begin
                sh       = sh - rdx;
                qbits[b] = 1'b1;
            end
            rem_w = sh[DW-1:0];
        end
        quot_next = {r_quot[MAG_W-BITS_PER_STEP-1:0], qbits};
    end

    assign rd_idx = r_nd[DIGIT_IDX_W-1:0] - DIGIT_IDX_W'(1);
    assign o_pop  = (r_state == B_IDLE) && !i_empty;

    always_comb begin
        n_state  = r_state;
        n_quot   = r_quot;
        n_rem    = r_rem;
        n_step   = r_step;
        n_nd     = r_nd;
        n_neg    = r_neg;
        n_strobe = 1'b0;
        n_symbol = r_symbol;
        n_last   = 1'b0;
        digit_wr = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_quot  = i_item.mag;
                    n_neg   = i_item.neg;
                    n_rem   = '0;
                    n_step  = '0;
                    n_nd    = '0;
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                n_quot = quot_next;
                n_rem  = rem_w;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    // Digit done: push it and decide whether more follow
                    digit_wr = 1'b1;
                    n_nd     = r_nd + DIGIT_CNT_W'(1);
                    n_rem    = '0;
                    if (quot_next == '0) begin
                        n_state = r_neg ? B_SIGN : B_EMIT;
                    end
                end
            end
            B_SIGN: begin
                n_strobe = 1'b1;
                n_symbol = MINUS_SYM;
                n_state  = B_EMIT;
            end
            B_EMIT: begin
                // Pop digits most significant first
                n_strobe = 1'b1;
                n_symbol = i_alpha[t_sym_idx'(r_digits[rd_idx])];
                n_last   = (r_nd == DIGIT_CNT_W'(1));
                n_nd     = r_nd - DIGIT_CNT_W'(1);
                if (r_nd == DIGIT_CNT_W'(1)) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Hold state, datapath and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_step   <= '0;
            r_nd     <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_nd     <= n_nd;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
        r_quot   <= n_quot;
        r_rem    <= n_rem;
        r_neg    <= n_neg;
        r_symbol <= n_symbol;
        if (digit_wr) begin
            r_digits[r_nd[DIGIT_IDX_W-1:0]] <= rem_w;
        end
    end

    assign o_strobe = r_strobe;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;

endmodule

// ===== src/signed_integer_to_radix_text_top.sv =====
// Signed integer to text in a configurable radix.
//
// Input: pulse i_start with i_value while o_busy is low; the value is taken
// at that edge. Output: one symbol byte per o_strobe cycle on o_symbol, most
// significant digit first, preceded by '-' for a negative value; o_last marks
// the final byte. The receiver cannot stall: each byte is shown for one cycle.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 radix,
// 1..4 alphabet words); write only while no conversion is pending.
//
// The front checks the alphabet one symbol per cycle and drops items with a
// bad radix or alphabet; o_busy is high during that check and until the item is
// queued. A two-entry queue decouples the front from the back, which finds each
// digit by long division (8 quotient bits per cycle), then emits the bytes back
// to back. The front can take a new value while the back still converts earlier
// ones, as long as the queue has room; the back's division loop sets the
// sustained pace.
// Reset restores radix 10 and the alphabet "0123456789" and empties the queue.
module signed_integer_to_radix_text_top
    import sitrt_pkg::*;
#(
    parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_W-1:0]    i_value,
    output logic                  o_busy,
    output logic                  o_strobe,
    output logic [SYM_W-1:0]      o_symbol,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [RADIX_W-1:0]    r_radix;
    logic [CFG_DATA_W-1:0] r_alpha_word [ALPHA_WORDS];
    t_alpha                alpha;

    logic  push;
    t_item push_item;
    logic  full;
    logic  pop;
    logic  empty;
    t_item pop_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix         <= RADIX_RESET;
            r_alpha_word[0] <= ALPHA_RESET_0;
            r_alpha_word[1] <= ALPHA_RESET_1;
            r_alpha_word[2] <= ALPHA_RESET_2;
            r_alpha_word[3] <= ALPHA_RESET_3;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RADIX:   r_radix         <= i_cfg_data[RADIX_W-1:0];
                CFG_ALPHA_0: r_alpha_word[0] <= i_cfg_data;
                CFG_ALPHA_1: r_alpha_word[1] <= i_cfg_data;
                CFG_ALPHA_2: r_alpha_word[2] <= i_cfg_data;
                CFG_ALPHA_3: r_alpha_word[3] <= i_cfg_data;
                default:     r_radix         <= r_radix;
            endcase
        end
    end

    assign alpha = {r_alpha_word[3], r_alpha_word[2], r_alpha_word[1], r_alpha_word[0]};

    sitrt_front #(
        .MAX_RADIX (MAX_RADIX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_value (i_value),
        .o_busy  (o_busy),
        .i_radix (r_radix),
        .i_alpha (alpha),
        .o_push  (push),
        .o_item  (push_item),
        .i_full  (full)
    );

    sitrt_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (pop_item)
    );

    sitrt_back #(
        .MAX_RADIX (MAX_RADIX)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_item   (pop_item),
        .o_pop    (pop),
        .i_radix  (r_radix),
        .i_alpha  (alpha),
        .o_strobe (o_strobe),
        .o_symbol (o_symbol),
        .o_last   (o_last)
    );

endmodule

// ===== src/sitrt_chk.sv =====
module sitrt_chk
    import sitrt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_start,
    input logic                  o_busy,
    input logic                  o_strobe,
    input logic [SYM_W-1:0]      o_symbol,
    input logic                  o_last
);

    // The bytes of one text come back to back until the last one
    a_text_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside a text");

    // A finished text is never followed by a byte in the next cycle
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("byte emitted right after the last byte of a text");

    // The sign never ends a text
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_symbol == MINUS_SYM)) |-> !o_last)
        else $error("sign byte marked as last");

    // Reset silences the output
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe raised after reset");

endmodule

bind signed_integer_to_radix_text_top sitrt_chk u_sitrt_chk (.*);
